// ===== src/i8up_pkg.sv =====
// i8up_pkg: shared types, limits and helpers of the int8 nearest upscale requant core.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package i8up_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_SCALE  = 8;

    // Field widths fixed by the register map.
    localparam int DIM_W  = 13;
    localparam int SCL_W  = 4;
    localparam int MULT_W = 24;
    localparam int PIX_W  = 8;
    localparam int ADDR_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Widths that follow from the limits.
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int REP_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int RS_W  = ROW_W + SCL_W;   // row * scale_h
    localparam int CS_W  = COL_W + SCL_W;   // col * scale_w
    localparam int OW_W  = DIM_W + SCL_W;   // width * scale_w, height * scale_h
    localparam int PROD_W = PIX_W + 1 + MULT_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_SCALE_H   = 3'd2,
        REG_SCALE_W   = 3'd3,
        REG_MULT      = 3'd4,
        REG_IN_ZP     = 3'd5,
        REG_OUT_ZP    = 3'd6
    } cfg_idx_e;

    // Configuration as held: dimensions and factors already clamped.
    typedef struct packed {
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic [SCL_W-1:0]        sh;
        logic [SCL_W-1:0]        sw;
        logic [MULT_W-1:0]       mult;
        logic signed [PIX_W-1:0] izp;
        logic signed [PIX_W-1:0] ozp;
    } cfg_t;

    // One classified pixel waiting for replication.
    typedef struct packed {
        logic signed [PIX_W-1:0] value;
        logic [ADDR_W-1:0]       addr;
        logic [OW_W-1:0]         out_w;
    } job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > hi)
            r = DIM_W'(hi);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SCL_W-1:0] clamp_scl(input logic [SCL_W-1:0] v);
        logic [SCL_W-1:0] r;
        if (v == '0)
            r = SCL_W'(1);
        else if (32'(v) > MAX_SCALE)
            r = SCL_W'(MAX_SCALE);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== src/i8up_ifs.sv =====
// i8up channel interfaces: pixel input, result output, configuration write.
// Depends on i8up_pkg for field widths.
`timescale 1ns / 1ps

interface i8up_pixel_if;
    logic                             valid;
    logic                             ready;
    logic signed [i8up_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface i8up_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [i8up_pkg::PIX_W-1:0]  out_value;
    logic [i8up_pkg::ADDR_W-1:0]        out_address;
    logic                              last_copy;

    modport source (output valid, output out_value, output out_address,
                    output last_copy, input ready);
    modport sink   (input valid, input out_value, input out_address,
                    input last_copy, output ready);
endinterface

interface i8up_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [i8up_pkg::CFG_IDX_W-1:0]      index;
    logic [i8up_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/i8up_front.sv =====
// i8up_front: accepts pixels, tracks column/row/plane, requantizes and
// computes the first output address. Depends on i8up_pkg, i8up_pixel_if.
`timescale 1ns / 1ps

module i8up_front (
    input  logic                clk,
    input  logic                rst_n,
    i8up_pixel_if.sink          pixel,
    input  i8up_pkg::cfg_t      cfg,
    input  logic                fifo_full,
    output logic                push,
    output i8up_pkg::job_t      push_job
);

    localparam int PW = i8up_pkg::PIX_W;

    logic adv;
    logic accept;

    // position counters
    logic [i8up_pkg::COL_W-1:0]  col_reg, col_next;
    logic [i8up_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                        wrap_now;
    logic [i8up_pkg::ADDR_W-1:0] plane_base_reg, plane_base_next;

    // stage 1: captured pixel and position
    logic                        s1_valid_reg;
    logic signed [PW-1:0]        s1_pix_reg;
    logic [i8up_pkg::COL_W-1:0]  s1_col_reg;
    logic [i8up_pkg::ROW_W-1:0]  s1_row_reg;
    logic                        s1_wrap_reg;

    // stage 2: products by the small factors and the requant product
    logic                        s2_valid_reg;
    logic signed [i8up_pkg::PROD_W-1:0] s2_prod_reg;
    logic [i8up_pkg::RS_W-1:0]   s2_row_sh_reg;
    logic [i8up_pkg::CS_W-1:0]   s2_col_sw_reg;
    logic [i8up_pkg::OW_W-1:0]   s2_out_w_reg;
    logic [i8up_pkg::OW_W-1:0]   s2_h_sh_reg;
    logic                        s2_wrap_reg;

    // stage 3: rounded value, line and plane offsets
    logic                        s3_valid_reg;
    logic signed [PW-1:0]        s3_q_reg;
    logic [i8up_pkg::ADDR_W-1:0] s3_line_off_reg;
    logic [i8up_pkg::CS_W-1:0]   s3_col_sw_reg;
    logic [i8up_pkg::OW_W-1:0]   s3_out_w_reg;
    logic [i8up_pkg::ADDR_W-1:0] s3_plane_sz_reg;
    logic                        s3_wrap_reg;

    logic signed [PW:0]                 diff;
    logic signed [i8up_pkg::PROD_W-1:0] prod;
    logic signed [i8up_pkg::ACC_W-1:0]  acc;
    logic [i8up_pkg::ACC_W-1:0]         mag;
    logic [i8up_pkg::ACC_W-1:0]         rnd;
    logic signed [PW-1:0]               q;
    logic [2*i8up_pkg::OW_W-1:0]        line_prod;
    logic [2*i8up_pkg::OW_W-1:0]        plane_prod;

    assign adv         = !(s3_valid_reg && fifo_full);
    assign pixel.ready = adv;
    assign accept      = pixel.valid && adv;

    // column/row advance as in raster order
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        wrap_now = 1'b0;
        if ((i8up_pkg::DIM_W'(col_reg) + i8up_pkg::DIM_W'(1)) >= cfg.w)
        begin
            col_next = '0;
            if ((i8up_pkg::DIM_W'(row_reg) + i8up_pkg::DIM_W'(1)) >= cfg.h)
            begin
                row_next = '0;
                wrap_now = 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign diff = (PW+1)'(s1_pix_reg) - (PW+1)'(cfg.izp);
    assign prod = i8up_pkg::PROD_W'(diff) * $signed({1'b0, cfg.mult});

    // round half away from zero, then saturate
    always_comb
    begin
        acc = i8up_pkg::ACC_W'(s2_prod_reg)
            + (i8up_pkg::ACC_W'(cfg.ozp) <<< i8up_pkg::FRAC_W);
        mag = acc[i8up_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
        rnd = (mag + (i8up_pkg::ACC_W'(1) << (i8up_pkg::FRAC_W - 1)))
            >> i8up_pkg::FRAC_W;
        if (acc[i8up_pkg::ACC_W-1])
            q = (rnd > i8up_pkg::ACC_W'(128)) ? PW'(-128) : PW'(~rnd + 1'b1);
        else
            q = (rnd > i8up_pkg::ACC_W'(127)) ? PW'(127) : PW'(rnd);
    end

    assign line_prod  = (2*i8up_pkg::OW_W)'(s2_row_sh_reg) * (2*i8up_pkg::OW_W)'(s2_out_w_reg);
    assign plane_prod = (2*i8up_pkg::OW_W)'(s2_h_sh_reg) * (2*i8up_pkg::OW_W)'(s2_out_w_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pixel.pixel_value;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_wrap_reg <= wrap_now;

            s2_prod_reg   <= prod;
            s2_row_sh_reg <= i8up_pkg::RS_W'(s1_row_reg) * i8up_pkg::RS_W'(cfg.sh);
            s2_col_sw_reg <= i8up_pkg::CS_W'(s1_col_reg) * i8up_pkg::CS_W'(cfg.sw);
            s2_out_w_reg  <= i8up_pkg::OW_W'(cfg.w) * i8up_pkg::OW_W'(cfg.sw);
            s2_h_sh_reg   <= i8up_pkg::OW_W'(cfg.h) * i8up_pkg::OW_W'(cfg.sh);
            s2_wrap_reg   <= s1_wrap_reg;

            s3_q_reg        <= q;
            s3_line_off_reg <= i8up_pkg::ADDR_W'(line_prod);
            s3_col_sw_reg   <= s2_col_sw_reg;
            s3_out_w_reg    <= s2_out_w_reg;
            s3_plane_sz_reg <= i8up_pkg::ADDR_W'(plane_prod);
            s3_wrap_reg     <= s2_wrap_reg;
        end
    end

    assign push = s3_valid_reg && !fifo_full;

    assign push_job.value = s3_q_reg;
    assign push_job.addr  = plane_base_reg + s3_line_off_reg
                          + i8up_pkg::ADDR_W'(s3_col_sw_reg);
    assign push_job.out_w = s3_out_w_reg;

    // plane base moves on once the last pixel of a plane has been issued
    assign plane_base_next = plane_base_reg + s3_plane_sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_base_reg <= '0;
        else if (push && s3_wrap_reg)
            plane_base_reg <= plane_base_next;
    end

endmodule

// ===== src/i8up_fifo.sv =====
// i8up_fifo: short job queue between the front and the back.
// Depends on i8up_pkg.
`timescale 1ns / 1ps

module i8up_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i8up_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output i8up_pkg::job_t  head_job
);

    i8up_pkg::job_t mem [i8up_pkg::FIFO_DEPTH];

    logic [i8up_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [i8up_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == i8up_pkg::FIFO_CNT_W'(i8up_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == i8up_pkg::FIFO_DEPTH - 1)
                            ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == i8up_pkg::FIFO_DEPTH - 1)
                            ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/i8up_back.sv =====
// i8up_back: replicates each job into scale_h x scale_w copies, one per cycle
// while not stalled, via an output register. Depends on i8up_pkg, i8up_result_if.
`timescale 1ns / 1ps

module i8up_back (
    input  logic            clk,
    input  logic            rst_n,
    input  i8up_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  i8up_pkg::job_t  head_job,
    output logic            pop,
    i8up_result_if.source   result
);

    logic                               cur_valid_reg;
    logic signed [i8up_pkg::PIX_W-1:0]  cur_value_reg;
    logic [i8up_pkg::ADDR_W-1:0]        line_reg;
    logic [i8up_pkg::OW_W-1:0]          out_w_reg;
    logic [i8up_pkg::REP_W-1:0]         rx_reg;
    logic [i8up_pkg::REP_W-1:0]         ry_reg;

    logic                               out_valid_reg;
    logic signed [i8up_pkg::PIX_W-1:0]  out_value_reg;
    logic [i8up_pkg::ADDR_W-1:0]        out_addr_reg;
    logic                               out_last_reg;

    logic emit;
    logic end_x;
    logic end_y;
    logic last;

    assign emit  = cur_valid_reg && (!out_valid_reg || result.ready);
    assign end_x = (i8up_pkg::SCL_W'(rx_reg) == cfg.sw - i8up_pkg::SCL_W'(1));
    assign end_y = (i8up_pkg::SCL_W'(ry_reg) == cfg.sh - i8up_pkg::SCL_W'(1));
    assign last  = end_x && end_y;
    assign pop   = head_valid && (!cur_valid_reg || (emit && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else if (pop)
            cur_valid_reg <= 1'b1;
        else if (emit && last)
            cur_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_value_reg <= head_job.value;
            line_reg      <= head_job.addr;
            out_w_reg     <= head_job.out_w;
            rx_reg        <= '0;
            ry_reg        <= '0;
        end
        else if (emit)
        begin
            if (end_x)
            begin
                rx_reg   <= '0;
                ry_reg   <= ry_reg + 1'b1;
                line_reg <= line_reg + i8up_pkg::ADDR_W'(out_w_reg);
            end
            else
            begin
                rx_reg <= rx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= cur_value_reg;
            out_addr_reg  <= line_reg + i8up_pkg::ADDR_W'(rx_reg);
            out_last_reg  <= last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.out_address = out_addr_reg;
    assign result.last_copy   = out_last_reg;

endmodule

// ===== src/int8_nearest_upscale_requant_core.sv =====
// int8_nearest_upscale_requant_core: top level with the configuration registers,
// front end, job queue and replication back end. Depends on i8up_pkg, i8up_ifs.
// Path: a pixel passes 3 front stages, the queue, the back end and the output reg
// before its first copy is offered. Throughput: the back end issues one copy per
// cycle into its output register while the output is not stalled, so each pixel
// gives scale_h*scale_w copies.
// Reset: registers return to defaults (1,1,1,1,65536,0,0); position, plane base
// and all valids clear at once; no clearing pass, configuration always ready.
`timescale 1ns / 1ps

module int8_nearest_upscale_requant_core (
    input  logic          clk,
    input  logic          rst_n,
    i8up_pixel_if.sink    pixel,
    i8up_result_if.source result,
    i8up_cfg_if.sink      cfg
);

    // Configuration held already clamped, so downstream sees legal values.
    i8up_pkg::cfg_t cfg_reg;

    // Front -> queue -> back
    logic           fifo_full;
    logic           push;
    i8up_pkg::job_t push_job;
    logic           pop;
    logic           head_valid;
    i8up_pkg::job_t head_job;

    // Writes are taken in any cycle; an index past the map is dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.w    <= i8up_pkg::DIM_W'(1);
            cfg_reg.h    <= i8up_pkg::DIM_W'(1);
            cfg_reg.sh   <= i8up_pkg::SCL_W'(1);
            cfg_reg.sw   <= i8up_pkg::SCL_W'(1);
            cfg_reg.mult <= i8up_pkg::MULT_W'(65536);
            cfg_reg.izp  <= '0;
            cfg_reg.ozp  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                i8up_pkg::REG_IN_WIDTH:
                    cfg_reg.w <= i8up_pkg::clamp_dim(cfg.data[i8up_pkg::DIM_W-1:0],
                                                     i8up_pkg::MAX_WIDTH);
                i8up_pkg::REG_IN_HEIGHT:
                    cfg_reg.h <= i8up_pkg::clamp_dim(cfg.data[i8up_pkg::DIM_W-1:0],
                                                     i8up_pkg::MAX_HEIGHT);
                i8up_pkg::REG_SCALE_H:
                    cfg_reg.sh <= i8up_pkg::clamp_scl(cfg.data[i8up_pkg::SCL_W-1:0]);
                i8up_pkg::REG_SCALE_W:
                    cfg_reg.sw <= i8up_pkg::clamp_scl(cfg.data[i8up_pkg::SCL_W-1:0]);
                i8up_pkg::REG_MULT:
                    cfg_reg.mult <= cfg.data[i8up_pkg::MULT_W-1:0];
                i8up_pkg::REG_IN_ZP:
                    cfg_reg.izp <= cfg.data[i8up_pkg::PIX_W-1:0];
                i8up_pkg::REG_OUT_ZP:
                    cfg_reg.ozp <= cfg.data[i8up_pkg::PIX_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Front: position tracking, requant pipeline, first address of each pixel.
    i8up_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .cfg      (cfg_reg),
        .fifo_full(fifo_full),
        .push     (push),
        .push_job (push_job)
    );

    // Queue decouples the multi-cycle replication from the front pipeline.
    i8up_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_job  (head_job)
    );

    // Back: walks column repeats within each row repeat, one copy per cycle unless stalled.
    i8up_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head_job  (head_job),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== src/i8up_checker.sv =====
// i8up_checker: port-level checks of the upscale core, bound to the top level.
// Depends on i8up_pkg for widths.
`timescale 1ns / 1ps

module i8up_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic signed [i8up_pkg::PIX_W-1:0]  res_value,
    input logic                              res_last,
    input logic                              cfg_ready
);

    // A waiting result holds until taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_last))
        else $error("result changed while stalled");

    // Copies of one pixel follow without a gap and carry the same value.
    a_copy_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid && res_value == $past(res_value))
        else $error("copy run broken");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid after reset");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind int8_nearest_upscale_requant_core i8up_checker u_i8up_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .res_value(result.out_value),
    .res_last (result.last_copy),
    .cfg_ready(cfg.ready)
);
